// ===== sv/uvs_pkg.sv =====
// shared types, constants and tables of the uv sphere vertex generator
package uvs_pkg;

    // pipeline shape of the index dividers
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned TEX_STEP  = 15;
    localparam int unsigned SEC_FRAC  = 32;
    localparam int unsigned STK_FRAC  = 31;

    // fixed-point constants
    localparam logic [31:0] ANG_QUARTER   = 32'h4000_0000;
    localparam logic [31:0] ANG_EIGHTH    = 32'h2000_0000;
    localparam logic [33:0] CORDIC_GAIN   = 34'd652032874;
    localparam logic [15:0] TEX_ONE       = 16'd32768;
    localparam logic [15:0] TEX_TOP       = 16'd328;
    localparam logic [15:0] TEX_BOTTOM    = 16'd32440;
    localparam logic signed [23:0] POS_LIMIT = 24'sd65535;

    // register map, one 32-bit word each
    typedef enum logic [1:0] {
        REG_RADIUS  = 2'd0,
        REG_SECTORS = 2'd1,
        REG_STACKS  = 2'd2
    } t_reg_idx;

    // quarter-turn codes of the cordic pre-rotation
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // fields that ride along the pipeline untouched by the math
    typedef struct packed {
        logic        oor;
        logic [15:0] tex_s;
        logic [15:0] tex_t;
    } t_side;

    // atan(2^-k) as a fraction of a full turn, 2^32 per turn
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // saturate a position to the symmetric q8.8 range
    function automatic logic signed [16:0] clamp_pos(input logic signed [23:0] v);
        logic signed [16:0] r;
        if (v > POS_LIMIT) begin
            r = 17'sd65535;
        end else if (v < -POS_LIMIT) begin
            r = -17'sd65535;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/uvs_div.sv =====
// pipelined restoring dividers that turn grid indices into angles and texture coordinates
module uvs_div #(
    parameter int unsigned MAX_DIVISIONS = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [7:0]         i_stack_index,
    input  logic [7:0]         i_sector_index,
    input  logic [7:0]         i_sector_count,
    input  logic [7:0]         i_stack_count,
    output logic               o_valid,
    output logic [31:0]        o_sec_ang,
    output logic [31:0]        o_stk_ang,
    output uvs_pkg::t_side     o_side
);

    localparam int unsigned NS = uvs_pkg::DIV_STEPS;

    // lane 0 is the sector index, lane 1 the stack index
    logic [7:0]  w_num [2];
    logic [7:0]  w_den [2];
    logic [7:0]  w_half [2];

    logic [8:0]  r_rem [2][NS+1];
    logic [32:0] r_quo [2][NS+1];
    logic [15:0] r_tex [2][NS+1];
    logic [32:0] r_ang [2][NS+1];
    logic        r_vld [NS+1];
    logic        r_oor [NS+1];
    logic        r_top [NS+1];
    logic        r_bot [NS+1];

    // counts clamped to the supported division limit
    always_comb begin
        w_num[0] = i_sector_index;
        w_num[1] = i_stack_index;
        w_den[0] = (32'(i_sector_count) > MAX_DIVISIONS) ? 8'(MAX_DIVISIONS) : i_sector_count;
        w_den[1] = (32'(i_stack_count) > MAX_DIVISIONS) ? 8'(MAX_DIVISIONS) : i_stack_count;
        w_half[0] = w_den[0] >> 1;
        w_half[1] = w_den[1] >> 1;
    end

    // entry stage: range check, pole flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oor[0] <= (w_den[0] == 8'd0) || (w_den[1] == 8'd0) ||
                        (i_sector_index > w_den[0]) || (i_stack_index > w_den[1]);
            r_top[0] <= (i_stack_index == 8'd0);
            r_bot[0] <= (i_stack_index == w_den[1]);
        end
    end

    genvar l, s;
    generate
        for (l = 0; l < 2; l++) begin : g_lane
            localparam int unsigned FRAC = (l == 0) ? uvs_pkg::SEC_FRAC : uvs_pkg::STK_FRAC;

            // integer quotient bit
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[l][0] <= {32'd0, (w_num[l] >= w_den[l])};
                    r_rem[l][0] <= (w_num[l] >= w_den[l]) ?
                                   ({1'b0, w_num[l]} - {1'b0, w_den[l]}) : {1'b0, w_num[l]};
                    r_tex[l][0] <= '0;
                    r_ang[l][0] <= '0;
                end
            end

            // one fractional quotient bit per stage
            for (s = 1; s <= NS; s++) begin : g_step
                logic [9:0]  w_t;
                logic        w_bit;
                logic [8:0]  w_r;
                logic [32:0] w_q;
                logic        w_c;

                always_comb begin
                    w_t   = {r_rem[l][s-1], 1'b0};
                    w_bit = (w_t >= {2'b00, w_den[l]});
                    w_r   = w_bit ? 9'(w_t - {2'b00, w_den[l]}) : w_t[8:0];
                    w_q   = {r_quo[l][s-1][31:0], w_bit};
                    // round up when remainder plus half divisor reaches the divisor
                    w_c   = ({1'b0, w_r} + {2'b00, w_half[l]}) >= {2'b00, w_den[l]};
                end

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[l][s] <= w_r;
                        r_quo[l][s] <= w_q;
                        r_tex[l][s] <= (s == uvs_pkg::TEX_STEP) ?
                                       16'(w_q[15:0] + {15'd0, w_c}) : r_tex[l][s-1];
                        r_ang[l][s] <= (s == FRAC) ? (w_q + {32'd0, w_c}) : r_ang[l][s-1];
                    end
                end
            end
        end

        // valid and side flags travel with the data
        for (s = 1; s <= NS; s++) begin : g_ctl
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_oor[s] <= r_oor[s-1];
                    r_top[s] <= r_top[s-1];
                    r_bot[s] <= r_bot[s-1];
                end
            end
        end
    endgenerate

    // stack angle counts down from the north pole
    always_comb begin
        o_valid      = r_vld[NS];
        o_sec_ang    = r_ang[0][NS][31:0];
        o_stk_ang    = uvs_pkg::ANG_QUARTER - r_ang[1][NS][31:0];
        o_side.oor   = r_oor[NS];
        o_side.tex_s = r_tex[0][NS];
        if (r_top[NS]) begin
            o_side.tex_t = uvs_pkg::TEX_TOP;
        end else if (r_bot[NS]) begin
            o_side.tex_t = uvs_pkg::TEX_BOTTOM;
        end else begin
            o_side.tex_t = uvs_pkg::TEX_ONE - r_tex[1][NS];
        end
    end

endmodule

// ===== sv/uvs_cordic.sv =====
// two unrolled rotation-mode cordic lanes giving cosine and sine in q2.30
module uvs_cordic #(
    parameter int unsigned ANGLE_ITERATIONS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [31:0]         i_sec_ang,
    input  logic [31:0]         i_stk_ang,
    input  uvs_pkg::t_side      i_side,
    output logic                o_valid,
    output logic signed [31:0]  o_sec_cos,
    output logic signed [31:0]  o_sec_sin,
    output logic signed [31:0]  o_stk_cos,
    output logic signed [31:0]  o_stk_sin,
    output uvs_pkg::t_side      o_side
);

    localparam int unsigned NI = ANGLE_ITERATIONS;

    logic [31:0]        w_ang [2];
    logic signed [33:0] r_x   [2][NI+1];
    logic signed [33:0] r_y   [2][NI+1];
    logic signed [32:0] r_z   [2][NI+1];
    uvs_pkg::t_quad     r_qd  [2][NI+1];
    logic signed [31:0] r_cos [2];
    logic signed [31:0] r_sin [2];
    logic               r_vld [NI+2];
    uvs_pkg::t_side     r_side [NI+2];

    assign w_ang[0] = i_sec_ang;
    assign w_ang[1] = i_stk_ang;

    genvar l, k;
    generate
        for (l = 0; l < 2; l++) begin : g_lane
            logic [31:0] w_rnd;
            logic [31:0] w_res;

            // quarter-turn pre-rotation leaves a residue within an eighth turn
            always_comb begin
                w_rnd = w_ang[l] + uvs_pkg::ANG_EIGHTH;
                w_res = w_ang[l] - {w_rnd[31:30], 30'd0};
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_qd[l][0] <= uvs_pkg::t_quad'(w_rnd[31:30]);
                    r_z[l][0]  <= {w_res[31], w_res};
                    r_x[l][0]  <= $signed(uvs_pkg::CORDIC_GAIN);
                    r_y[l][0]  <= '0;
                end
            end

            // micro-rotations, one per stage
            for (k = 0; k < NI; k++) begin : g_iter
                logic signed [32:0] w_atan;
                assign w_atan = $signed({1'b0, uvs_pkg::atan_turn(5'(k))});

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_qd[l][k+1] <= r_qd[l][k];
                        if (!r_z[l][k][32]) begin
                            r_x[l][k+1] <= r_x[l][k] - (r_y[l][k] >>> k);
                            r_y[l][k+1] <= r_y[l][k] + (r_x[l][k] >>> k);
                            r_z[l][k+1] <= r_z[l][k] - w_atan;
                        end else begin
                            r_x[l][k+1] <= r_x[l][k] + (r_y[l][k] >>> k);
                            r_y[l][k+1] <= r_y[l][k] - (r_x[l][k] >>> k);
                            r_z[l][k+1] <= r_z[l][k] + w_atan;
                        end
                    end
                end
            end

            // undo the quarter-turn rotation
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    case (r_qd[l][NI])
                        uvs_pkg::QUAD_0: begin
                            r_cos[l] <= 32'(r_x[l][NI]);
                            r_sin[l] <= 32'(r_y[l][NI]);
                        end
                        uvs_pkg::QUAD_1: begin
                            r_cos[l] <= 32'(-r_y[l][NI]);
                            r_sin[l] <= 32'(r_x[l][NI]);
                        end
                        uvs_pkg::QUAD_2: begin
                            r_cos[l] <= 32'(-r_x[l][NI]);
                            r_sin[l] <= 32'(-r_y[l][NI]);
                        end
                        default: begin
                            r_cos[l] <= 32'(r_y[l][NI]);
                            r_sin[l] <= 32'(-r_x[l][NI]);
                        end
                    endcase
                end
            end
        end

        // valid and side fields follow the lanes
        for (k = 0; k < NI + 2; k++) begin : g_ctl
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[k] <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    assign o_valid   = r_vld[NI+1];
    assign o_side    = r_side[NI+1];
    assign o_sec_cos = r_cos[0];
    assign o_sec_sin = r_sin[0];
    assign o_stk_cos = r_cos[1];
    assign o_stk_sin = r_sin[1];

endmodule

// ===== sv/uvs_scale.sv =====
// radius scaling, rounding and saturation, ending in the output register
module uvs_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [15:0]         i_radius,
    input  logic signed [31:0]  i_sec_cos,
    input  logic signed [31:0]  i_sec_sin,
    input  logic signed [31:0]  i_stk_cos,
    input  logic signed [31:0]  i_stk_sin,
    input  uvs_pkg::t_side      i_side,
    output logic                o_valid,
    output logic signed [16:0]  o_pos_x,
    output logic signed [16:0]  o_pos_y,
    output logic signed [16:0]  o_pos_z,
    output logic [15:0]         o_tex_s,
    output logic [15:0]         o_tex_t,
    output logic                o_out_of_range
);

    logic [3:0]         r_vld;
    uvs_pkg::t_side     r_side [3];
    logic signed [48:0] r_pxy;
    logic signed [48:0] r_pz;
    logic signed [31:0] r_ss1, r_cs1, r_ss2, r_cs2;
    logic signed [26:0] r_xy;
    logic signed [16:0] r_z2, r_z3;
    logic signed [58:0] r_px, r_py;

    logic signed [48:0] w_xy_sum, w_z_sum;
    logic signed [58:0] w_x_sum, w_y_sum;
    logic signed [18:0] w_z_rs;
    logic signed [20:0] w_x_rs, w_y_rs;

    // round-half-up shifts
    always_comb begin
        w_xy_sum = r_pxy + (49'sd1 <<< 21);
        w_z_sum  = r_pz + (49'sd1 <<< 29);
        w_z_rs   = w_z_sum[48:30];
        w_x_sum  = r_px + (59'sd1 <<< 37);
        w_y_sum  = r_py + (59'sd1 <<< 37);
        w_x_rs   = w_x_sum[58:38];
        w_y_rs   = w_y_sum[58:38];
    end

    // valid chain, output valid last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // stage 1: radius times stack cosine and sine
    // stage 2: horizontal radius and height
    // stage 3: horizontal radius times sector sine and cosine
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxy     <= $signed({1'b0, i_radius}) * i_stk_cos;
            r_pz      <= $signed({1'b0, i_radius}) * i_stk_sin;
            r_ss1     <= i_sec_sin;
            r_cs1     <= i_sec_cos;
            r_side[0] <= i_side;

            r_xy      <= w_xy_sum[48:22];
            r_z2      <= uvs_pkg::clamp_pos({{5{w_z_rs[18]}}, w_z_rs});
            r_ss2     <= r_ss1;
            r_cs2     <= r_cs1;
            r_side[1] <= r_side[0];

            r_px      <= r_xy * r_ss2;
            r_py      <= r_xy * r_cs2;
            r_z3      <= r_z2;
            r_side[2] <= r_side[1];
        end
    end

    // output register, fields cleared for an index out of range
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_side[2].oor) begin
                o_pos_x        <= '0;
                o_pos_y        <= '0;
                o_pos_z        <= '0;
                o_tex_s        <= '0;
                o_tex_t        <= '0;
                o_out_of_range <= 1'b1;
            end else begin
                o_pos_x        <= uvs_pkg::clamp_pos({{3{w_x_rs[20]}}, w_x_rs});
                o_pos_y        <= uvs_pkg::clamp_pos({{3{w_y_rs[20]}}, w_y_rs});
                o_pos_z        <= r_z3;
                o_tex_s        <= r_side[2].tex_s;
                o_tex_t        <= r_side[2].tex_t;
                o_out_of_range <= 1'b0;
            end
        end
    end

    assign o_valid = r_vld[3];

endmodule

// ===== sv/uv_sphere_vertex_generator_top.sv =====
// uv sphere vertex generator: config registers, stall control and pipeline
//
//  port group   dir   width  contents
//  s_axis_*     in    16     stack_index [7:0], sector_index [15:8]
//  m_axis_*     out   88     pos_x, pos_y, pos_z, tex_s, tex_t; tuser out_of_range
//  apb          in/out 32    radius @0x0, sector_count @0x4, stack_count @0x8
//
// one grid point enters per cycle unless the output stalls; the pipeline holds 33 divider
// stages, ANGLE_ITERATIONS + 2 cordic stages and 4 scaling stages, with a default of 16 iterations
// synchronous active-low reset clears all valid bits and loads the default registers
// the whole pipeline holds while the output register carries a transfer not yet taken
module uv_sphere_vertex_generator_top #(
    parameter int unsigned MAX_DIVISIONS    = 255,
    parameter int unsigned ANGLE_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // stack_index, sector_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // pos_x, pos_y, pos_z, tex_s, tex_t, zero pad
    output logic        m_axis_tuser,   // out_of_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_radius;
    logic [7:0]  r_sectors;
    logic [7:0]  r_stacks;
    logic        w_en;
    logic        w_wr;
    uvs_pkg::t_reg_idx w_idx;

    logic               w_div_vld, w_cor_vld;
    logic [31:0]        w_sec_ang, w_stk_ang;
    uvs_pkg::t_side     w_div_side, w_cor_side;
    logic signed [31:0] w_sec_cos, w_sec_sin, w_stk_cos, w_stk_sin;
    logic signed [16:0] w_pos_x, w_pos_y, w_pos_z;
    logic [15:0]        w_tex_s, w_tex_t;

    // register writes
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = uvs_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= 16'd256;
            r_sectors <= 8'd36;
            r_stacks  <= 8'd18;
        end else if (w_wr) begin
            case (w_idx)
                uvs_pkg::REG_RADIUS:  r_radius  <= pwdata[15:0];
                uvs_pkg::REG_SECTORS: r_sectors <= pwdata[7:0];
                uvs_pkg::REG_STACKS:  r_stacks  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (w_idx)
            uvs_pkg::REG_RADIUS:  prdata = {16'd0, r_radius};
            uvs_pkg::REG_SECTORS: prdata = {24'd0, r_sectors};
            uvs_pkg::REG_STACKS:  prdata = {24'd0, r_stacks};
            default:              prdata = '0;
        endcase
    end

    // pipeline advances unless a finished transfer is held
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    uvs_div #(
        .MAX_DIVISIONS (MAX_DIVISIONS)
    ) u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (s_axis_tvalid),
        .i_stack_index  (s_axis_tdata[7:0]),
        .i_sector_index (s_axis_tdata[15:8]),
        .i_sector_count (r_sectors),
        .i_stack_count  (r_stacks),
        .o_valid        (w_div_vld),
        .o_sec_ang      (w_sec_ang),
        .o_stk_ang      (w_stk_ang),
        .o_side         (w_div_side)
    );

    uvs_cordic #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_div_vld),
        .i_sec_ang (w_sec_ang),
        .i_stk_ang (w_stk_ang),
        .i_side    (w_div_side),
        .o_valid   (w_cor_vld),
        .o_sec_cos (w_sec_cos),
        .o_sec_sin (w_sec_sin),
        .o_stk_cos (w_stk_cos),
        .o_stk_sin (w_stk_sin),
        .o_side    (w_cor_side)
    );

    uvs_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (w_cor_vld),
        .i_radius       (r_radius),
        .i_sec_cos      (w_sec_cos),
        .i_sec_sin      (w_sec_sin),
        .i_stk_cos      (w_stk_cos),
        .i_stk_sin      (w_stk_sin),
        .i_side         (w_cor_side),
        .o_valid        (m_axis_tvalid),
        .o_pos_x        (w_pos_x),
        .o_pos_y        (w_pos_y),
        .o_pos_z        (w_pos_z),
        .o_tex_s        (w_tex_s),
        .o_tex_t        (w_tex_t),
        .o_out_of_range (m_axis_tuser)
    );

    // result packing, lowest field first
    assign m_axis_tdata = {5'd0, w_tex_t, w_tex_s, w_pos_z, w_pos_y, w_pos_x};

    // an out-of-range result carries nothing but the flag
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("out-of-range result with nonzero fields");

    // texture coordinates never pass 1.0
    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            w_tex_s <= uvs_pkg::TEX_ONE && w_tex_t <= uvs_pkg::TEX_ONE)
        else $error("texture coordinate above one");

    // saturation keeps positions off the most negative code
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_pos_x != 17'sh1_0000 && w_pos_y != 17'sh1_0000 &&
            w_pos_z != 17'sh1_0000)
        else $error("position outside saturation range");

    // a held result stalls the input side in the same cycle
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

endmodule
